// ----- rtl/sass_pkg.sv -----
`timescale 1ns / 1ps
package sass_pkg;

   localparam int MAX_TEXT_DEF    = 4096;
   localparam int MAX_PATTERN_DEF = 1024;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   localparam logic [2:0] CMD_TEXT    = 3'd0;
   localparam logic [2:0] CMD_BUILD   = 3'd1;
   localparam logic [2:0] CMD_PATTERN = 3'd2;
   localparam logic [2:0] CMD_QUERY   = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   // one-cycle commands from the controller to the datapath
   typedef struct packed {
      logic text_wr;
      logic pat_wr;
      logic text_clr;
      logic idx_set;
      logic plen_clr;
      logic text_rd;
      logic pat_rd;
      logic ord_rd;
      logic ord_wr;
      logic rank_rd;
      logic rank_wr;
   } dp_ctl_type;

endpackage

// ----- rtl/sass_datapath.sv -----
`timescale 1ns / 1ps
module sass_datapath #(
   parameter int MAX_TEXT    = sass_pkg::MAX_TEXT_DEF,
   parameter int MAX_PATTERN = sass_pkg::MAX_PATTERN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sass_pkg::dp_ctl_type       ctl,
   input  logic [7:0]                 char_byte,
   input  logic [$clog2(MAX_TEXT)-1:0] text_raddr,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
   input  logic [$clog2(MAX_TEXT):0]  ord_raddr,
   input  logic [$clog2(MAX_TEXT):0]  ord_waddr,
   input  logic [$clog2(MAX_TEXT)-1:0] ord_wdata,
   input  logic [$clog2(MAX_TEXT):0]  rank_raddr,
   input  logic [$clog2(MAX_TEXT):0]  rank_waddr,
   input  logic [(($clog2(MAX_TEXT) > 8) ? $clog2(MAX_TEXT) : 8)-1:0] rank_wdata,
   output logic [7:0]                 text_q,
   output logic [7:0]                 pat_q,
   output logic [$clog2(MAX_TEXT)-1:0] ord_q,
   output logic [(($clog2(MAX_TEXT) > 8) ? $clog2(MAX_TEXT) : 8)-1:0] rank_q,
   output logic [$clog2(MAX_TEXT):0]  text_len,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1):0] pat_len,
   output logic [$clog2(MAX_TEXT):0]  idx_len,
   output logic                       ovf
);

   localparam int IW = $clog2(MAX_TEXT);
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RW = (IW > 8) ? IW : 8;
   localparam int BD = 2 << IW;

   logic [7:0]    text_mem [0:MAX_TEXT-1];
   logic [7:0]    pat_mem  [0:MAX_PATTERN-1];
   logic [IW-1:0] ord_mem  [0:BD-1];
   logic [RW-1:0] rank_mem [0:BD-1];

   logic [7:0]    text_q_ff, pat_q_ff;
   logic [IW-1:0] ord_q_ff;
   logic [RW-1:0] rank_q_ff;

   logic [IW:0] tlen_ff, tlen_in, idx_ff, idx_in;
   logic [PW:0] plen_ff, plen_in;
   logic        ovf_ff, ovf_in;
   logic        text_room, pat_room;

   assign text_room = tlen_ff < (IW+1)'(MAX_TEXT);
   assign pat_room  = plen_ff < (PW+1)'(MAX_PATTERN);

   always_comb begin
      tlen_in = tlen_ff;
      idx_in  = idx_ff;
      plen_in = plen_ff;
      ovf_in  = ovf_ff;
      if (ctl.text_wr) begin
         if (text_room) tlen_in = tlen_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (ctl.pat_wr) begin
         if (pat_room) plen_in = plen_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (ctl.idx_set) idx_in = tlen_ff;
      if (ctl.plen_clr) plen_in = '0;
      if (ctl.text_clr) begin
         tlen_in = '0;
         idx_in  = '0;
         ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff <= '0;
         idx_ff  <= '0;
         plen_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         tlen_ff <= tlen_in;
         idx_ff  <= idx_in;
         plen_ff <= plen_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.text_wr && text_room) text_mem[tlen_ff[IW-1:0]] <= char_byte;
      if (ctl.text_rd) text_q_ff <= text_mem[text_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.pat_wr && pat_room) pat_mem[plen_ff[PW-1:0]] <= char_byte;
      if (ctl.pat_rd) pat_q_ff <= pat_mem[pat_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.ord_wr) ord_mem[ord_waddr] <= ord_wdata;
      if (ctl.ord_rd) ord_q_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.rank_wr) rank_mem[rank_waddr] <= rank_wdata;
      if (ctl.rank_rd) rank_q_ff <= rank_mem[rank_raddr];
   end

   assign text_q   = text_q_ff;
   assign pat_q    = pat_q_ff;
   assign ord_q    = ord_q_ff;
   assign rank_q   = rank_q_ff;
   assign text_len = tlen_ff;
   assign pat_len  = plen_ff;
   assign idx_len  = idx_ff;
   assign ovf      = ovf_ff;

endmodule

// ----- rtl/sass_control.sv -----
`timescale 1ns / 1ps
module sass_control #(
   parameter int MAX_TEXT    = sass_pkg::MAX_TEXT_DEF,
   parameter int MAX_PATTERN = sass_pkg::MAX_PATTERN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [2:0]                 req_cmd,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic                       rsp_found,
   output logic                       rsp_overflow,
   output sass_pkg::dp_ctl_type       ctl,
   output logic [$clog2(MAX_TEXT)-1:0] text_raddr,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
   output logic [$clog2(MAX_TEXT):0]  ord_raddr,
   output logic [$clog2(MAX_TEXT):0]  ord_waddr,
   output logic [$clog2(MAX_TEXT)-1:0] ord_wdata,
   output logic [$clog2(MAX_TEXT):0]  rank_raddr,
   output logic [$clog2(MAX_TEXT):0]  rank_waddr,
   output logic [(($clog2(MAX_TEXT) > 8) ? $clog2(MAX_TEXT) : 8)-1:0] rank_wdata,
   input  logic [7:0]                 text_q,
   input  logic [7:0]                 pat_q,
   input  logic [$clog2(MAX_TEXT)-1:0] ord_q,
   input  logic [(($clog2(MAX_TEXT) > 8) ? $clog2(MAX_TEXT) : 8)-1:0] rank_q,
   input  logic [$clog2(MAX_TEXT):0]  text_len,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1):0] pat_len,
   input  logic [$clog2(MAX_TEXT):0]  idx_len,
   input  logic                       ovf
);

   localparam int IW = $clog2(MAX_TEXT);
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RW = (IW > 8) ? IW : 8;
   localparam int LW = IW + 2;
   localparam int SW = ((IW > PW) ? IW : PW) + 2;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_INIT_RD  = 5'd1;
   localparam logic [4:0] S_INIT_WR  = 5'd2;
   localparam logic [4:0] S_W_START  = 5'd3;
   localparam logic [4:0] S_RUN      = 5'd4;
   localparam logic [4:0] S_STEP     = 5'd5;
   localparam logic [4:0] S_FA       = 5'd6;
   localparam logic [4:0] S_FB       = 5'd7;
   localparam logic [4:0] S_MERGE    = 5'd8;
   localparam logic [4:0] S_COPY     = 5'd9;
   localparam logic [4:0] S_CMP0     = 5'd10;
   localparam logic [4:0] S_CMP1     = 5'd11;
   localparam logic [4:0] S_CMP2     = 5'd12;
   localparam logic [4:0] S_CMP3     = 5'd13;
   localparam logic [4:0] S_CMP4     = 5'd14;
   localparam logic [4:0] S_CMP5     = 5'd15;
   localparam logic [4:0] S_RR_START = 5'd16;
   localparam logic [4:0] S_RR_WR0   = 5'd17;
   localparam logic [4:0] S_RR_STEP  = 5'd18;
   localparam logic [4:0] S_RR_FA    = 5'd19;
   localparam logic [4:0] S_RR_FB    = 5'd20;
   localparam logic [4:0] S_RR_WR    = 5'd21;
   localparam logic [4:0] S_NEXT     = 5'd22;
   localparam logic [4:0] S_Q_LOOP   = 5'd23;
   localparam logic [4:0] S_Q_P      = 5'd24;
   localparam logic [4:0] S_Q_CMP    = 5'd25;
   localparam logic [4:0] S_Q_CMP2   = 5'd26;
   localparam logic [4:0] S_Q_DEC    = 5'd27;
   localparam logic [4:0] S_Q_DONE   = 5'd28;

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic [IW:0]   n_ff, n_in;
   logic [LW-1:0] lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, w_ff, w_in, step_ff, step_in;
   logic [IW-1:0] cx_ff, cx_in, cy_ff, cy_in, top_ff, top_in, p_ff, p_in;
   logic [RW-1:0] kx1_ff, kx1_in, ky1_ff, ky1_in;
   logic [RW:0]   kx2_ff, kx2_in, ky2_ff, ky2_in;
   logic          less_ff, less_in, sb_ff, sb_in, rb_ff, rb_in;
   logic          first_ff, first_in, copy_j_ff, copy_j_in;
   logic [IW:0]   l_ff, l_in, r_ff, r_in, m_ff, m_in;
   logic [PW:0]   jj_ff, jj_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [LW-1:0] n_l, xs, ys, lo_w, lo_2w, ns;
   logic [SW-1:0] pj;
   logic [IW+1:0] lr_sum;
   logic [IW-1:0] new_top;

   assign n_l    = LW'(n_ff);
   assign xs     = LW'(cx_ff) + step_ff;
   assign ys     = LW'(cy_ff) + step_ff;
   assign lo_w   = lo_ff + w_ff;
   assign lo_2w  = lo_ff + (w_ff << 1);
   assign ns     = first_ff ? LW'(1) : (step_ff << 1);
   assign pj     = SW'(p_ff) + SW'(jj_ff);
   assign lr_sum = (IW+2)'(l_ff) + (IW+2)'(r_ff);
   assign new_top = top_ff + IW'(less_ff);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  n_in = n_ff;
      lo_in = lo_ff;  mid_in = mid_ff;  hi_in = hi_ff;
      i_in = i_ff;  j_in = j_ff;  k_in = k_ff;  w_in = w_ff;  step_in = step_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  top_in = top_ff;  p_in = p_ff;
      kx1_in = kx1_ff;  ky1_in = ky1_ff;  kx2_in = kx2_ff;  ky2_in = ky2_ff;
      less_in = less_ff;  sb_in = sb_ff;  rb_in = rb_ff;
      first_in = first_ff;  copy_j_in = copy_j_ff;
      l_in = l_ff;  r_in = r_ff;  m_in = m_ff;  jj_in = jj_ff;  found_in = found_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_found_in = rsp_found_ff;  rsp_ovf_in = rsp_ovf_ff;
      ctl = '0;
      text_raddr = '0;  pat_raddr = '0;
      ord_raddr = '0;  ord_waddr = '0;  ord_wdata = '0;
      rank_raddr = '0;  rank_waddr = '0;  rank_wdata = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  sass_pkg::CMD_TEXT:    ctl.text_wr = 1'b1;
                  sass_pkg::CMD_PATTERN: ctl.pat_wr = 1'b1;
                  sass_pkg::CMD_CLEAR:   ctl.text_clr = 1'b1;
                  sass_pkg::CMD_BUILD: begin
                     ctl.idx_set = 1'b1;
                     n_in = text_len;
                     sb_in = 1'b0;
                     rb_in = 1'b0;
                     first_in = 1'b1;
                     i_in = '0;
                     if (text_len != '0) state_in = S_INIT_RD;
                  end
                  sass_pkg::CMD_QUERY: begin
                     n_in = idx_len;
                     l_in = '0;
                     r_in = idx_len;
                     state_in = S_Q_LOOP;
                  end
                  default: ;
               endcase
            end
         end
         // identity order and byte ranks
         S_INIT_RD: begin
            if (i_ff < n_l) begin
               ctl.text_rd = 1'b1;
               text_raddr = i_ff[IW-1:0];
               state_in = S_INIT_WR;
            end else begin
               step_in = '0;
               w_in = LW'(1);
               state_in = S_W_START;
            end
         end
         S_INIT_WR: begin
            ctl.ord_wr = 1'b1;
            ord_waddr = {1'b0, i_ff[IW-1:0]};
            ord_wdata = i_ff[IW-1:0];
            ctl.rank_wr = 1'b1;
            rank_waddr = {1'b0, i_ff[IW-1:0]};
            rank_wdata = RW'(text_q);
            i_in = i_ff + 1'b1;
            state_in = S_INIT_RD;
         end
         // bottom-up merge sort, order ping-pongs between banks
         S_W_START: begin
            if (w_ff < n_l) begin
               lo_in = '0;
               state_in = S_RUN;
            end else begin
               state_in = S_RR_START;
            end
         end
         S_RUN: begin
            if (lo_ff < n_l) begin
               mid_in = (lo_w < n_l) ? lo_w : n_l;
               hi_in = (lo_2w < n_l) ? lo_2w : n_l;
               i_in = lo_ff;
               j_in = (lo_w < n_l) ? lo_w : n_l;
               k_in = lo_ff;
               state_in = S_STEP;
            end else begin
               sb_in = ~sb_ff;
               w_in = w_ff << 1;
               state_in = S_W_START;
            end
         end
         S_STEP: begin
            ctl.ord_rd = 1'b1;
            if (i_ff < mid_ff && j_ff < hi_ff) begin
               ord_raddr = {sb_ff, j_ff[IW-1:0]};
               state_in = S_FA;
            end else if (i_ff < mid_ff) begin
               ord_raddr = {sb_ff, i_ff[IW-1:0]};
               copy_j_in = 1'b0;
               state_in = S_COPY;
            end else if (j_ff < hi_ff) begin
               ord_raddr = {sb_ff, j_ff[IW-1:0]};
               copy_j_in = 1'b1;
               state_in = S_COPY;
            end else begin
               ctl.ord_rd = 1'b0;
               lo_in = lo_2w;
               state_in = S_RUN;
            end
         end
         S_FA: begin
            cx_in = ord_q;
            ctl.ord_rd = 1'b1;
            ord_raddr = {sb_ff, i_ff[IW-1:0]};
            state_in = S_FB;
         end
         S_FB: begin
            cy_in = ord_q;
            ret_in = S_MERGE;
            state_in = S_CMP0;
         end
         S_MERGE: begin
            ctl.ord_wr = 1'b1;
            ord_waddr = {~sb_ff, k_ff[IW-1:0]};
            ord_wdata = less_ff ? cx_ff : cy_ff;
            if (less_ff) j_in = j_ff + 1'b1;
            else i_in = i_ff + 1'b1;
            k_in = k_ff + 1'b1;
            state_in = S_STEP;
         end
         S_COPY: begin
            ctl.ord_wr = 1'b1;
            ord_waddr = {~sb_ff, k_ff[IW-1:0]};
            ord_wdata = ord_q;
            if (copy_j_ff) j_in = j_ff + 1'b1;
            else i_in = i_ff + 1'b1;
            k_in = k_ff + 1'b1;
            state_in = S_STEP;
         end
         // key compare of cx against cy, result in less
         S_CMP0: begin
            ctl.rank_rd = 1'b1;
            rank_raddr = {rb_ff, cx_ff};
            state_in = S_CMP1;
         end
         S_CMP1: begin
            kx1_in = rank_q;
            ctl.rank_rd = 1'b1;
            rank_raddr = {rb_ff, cy_ff};
            state_in = S_CMP2;
         end
         S_CMP2: begin
            ky1_in = rank_q;
            ctl.rank_rd = (xs < n_l);
            rank_raddr = {rb_ff, xs[IW-1:0]};
            state_in = S_CMP3;
         end
         S_CMP3: begin
            kx2_in = (xs < n_l) ? ((RW+1)'(rank_q) + 1'b1) : '0;
            ctl.rank_rd = (ys < n_l);
            rank_raddr = {rb_ff, ys[IW-1:0]};
            state_in = S_CMP4;
         end
         S_CMP4: begin
            ky2_in = (ys < n_l) ? ((RW+1)'(rank_q) + 1'b1) : '0;
            state_in = S_CMP5;
         end
         S_CMP5: begin
            less_in = (kx1_ff != ky1_ff) ? (kx1_ff < ky1_ff) : (kx2_ff < ky2_ff);
            state_in = ret_ff;
         end
         // new ranks into the other rank bank
         S_RR_START: begin
            ctl.ord_rd = 1'b1;
            ord_raddr = {sb_ff, {IW{1'b0}}};
            state_in = S_RR_WR0;
         end
         S_RR_WR0: begin
            ctl.rank_wr = 1'b1;
            rank_waddr = {~rb_ff, ord_q};
            rank_wdata = '0;
            top_in = '0;
            i_in = LW'(1);
            state_in = S_RR_STEP;
         end
         S_RR_STEP: begin
            if (i_ff < n_l) begin
               ctl.ord_rd = 1'b1;
               ord_raddr = {sb_ff, i_ff[IW-1:0] - 1'b1};
               state_in = S_RR_FA;
            end else begin
               rb_in = ~rb_ff;
               state_in = S_NEXT;
            end
         end
         S_RR_FA: begin
            cx_in = ord_q;
            ctl.ord_rd = 1'b1;
            ord_raddr = {sb_ff, i_ff[IW-1:0]};
            state_in = S_RR_FB;
         end
         S_RR_FB: begin
            cy_in = ord_q;
            ret_in = S_RR_WR;
            state_in = S_CMP0;
         end
         S_RR_WR: begin
            ctl.rank_wr = 1'b1;
            rank_waddr = {~rb_ff, cy_ff};
            rank_wdata = RW'(new_top);
            top_in = new_top;
            i_in = i_ff + 1'b1;
            state_in = S_RR_STEP;
         end
         S_NEXT: begin
            first_in = 1'b0;
            if (ns < n_l && ((IW+1)'(top_ff) + 1'b1) < n_ff) begin
               step_in = ns;
               w_in = LW'(1);
               state_in = S_W_START;
            end else begin
               state_in = S_IDLE;
            end
         end
         // binary search over the suffix order
         S_Q_LOOP: begin
            if (l_ff < r_ff) begin
               m_in = lr_sum[IW+1:1];
               ctl.ord_rd = 1'b1;
               ord_raddr = {sb_ff, lr_sum[IW:1]};
               state_in = S_Q_P;
            end else begin
               found_in = 1'b0;
               state_in = S_Q_DONE;
            end
         end
         S_Q_P: begin
            p_in = ord_q;
            jj_in = '0;
            state_in = S_Q_CMP;
         end
         S_Q_CMP: begin
            if (jj_ff < pat_len && pj < SW'(n_ff)) begin
               ctl.text_rd = 1'b1;
               text_raddr = pj[IW-1:0];
               ctl.pat_rd = 1'b1;
               pat_raddr = jj_ff[PW-1:0];
               state_in = S_Q_CMP2;
            end else begin
               state_in = S_Q_DEC;
            end
         end
         S_Q_CMP2: begin
            if (text_q == pat_q) begin
               jj_in = jj_ff + 1'b1;
               state_in = S_Q_CMP;
            end else begin
               state_in = S_Q_DEC;
            end
         end
         S_Q_DEC: begin
            if (jj_ff == pat_len) begin
               found_in = 1'b1;
               state_in = S_Q_DONE;
            end else if (pj >= SW'(n_ff) || text_q < pat_q) begin
               l_in = m_ff + 1'b1;
               state_in = S_Q_LOOP;
            end else begin
               r_in = m_ff;
               state_in = S_Q_LOOP;
            end
         end
         S_Q_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_ovf_in = ovf;
               ctl.plen_clr = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  n_ff <= n_in;
      lo_ff <= lo_in;  mid_ff <= mid_in;  hi_ff <= hi_in;
      i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;  w_ff <= w_in;  step_ff <= step_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  top_ff <= top_in;  p_ff <= p_in;
      kx1_ff <= kx1_in;  ky1_ff <= ky1_in;  kx2_ff <= kx2_in;  ky2_ff <= ky2_in;
      less_ff <= less_in;  sb_ff <= sb_in;  rb_ff <= rb_in;
      first_ff <= first_in;  copy_j_ff <= copy_j_in;
      l_ff <= l_in;  r_ff <= r_in;  m_ff <= m_in;  jj_ff <= jj_in;  found_ff <= found_in;
      rsp_found_ff <= rsp_found_in;  rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_ovf_ff;

`ifndef SYNTH
   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE || state_ff == S_COPY) |-> (k_ff < hi_ff))
      else $error("merge write outside its run");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RR_WR) |-> ((LW'(top_ff) < i_ff) && (i_ff < n_l)))
      else $error("rank ran ahead of position");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_LOOP) |-> ((l_ff <= r_ff + 1'b1) && (r_ff <= n_ff)))
      else $error("search window out of range");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_DONE && state_in == S_IDLE) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("query finished without result");
`endif

endmodule

// ----- rtl/suffix_array_substring_search.sv -----
`timescale 1ns / 1ps
// Substring search over a suffix array built by prefix doubling.
// req channel: one command per transfer, tdata = {pad, char_byte[10:3], cmd[2:0]}.
//   cmd 0 appends a text byte, 2 appends a pattern byte, 1 builds the index,
//   3 runs a query, 4 clears text, index and overflow flag; 5 to 7 do nothing.
// rsp channel: one transfer per query, tdata = {pad, overflow[1], found[0]}.
// Byte appends, clear and unused commands are done in the idle state.
// Build of n bytes: the ranks are loaded from the text, then each doubling
//   round runs a merge sort and a re-ranking pass; each key compare reads
//   both keys through the single rank memory read port, and there are at
//   most ceil(log2(n))+1 rounds.
// Query: at most log2(n)+1 binary search probes, each matching the pattern
//   byte by byte against one suffix, then the result register is loaded.
// Only one command is in work at a time; req_tready is high while idle.
// A finished result waits in the output register; while the receiver stalls, other
//   commands are taken, but the next query waits at its result and blocks all input.
// Reset empties text, pattern and index and clears the overflow flag; no
//   memory clearing pass is needed.
module suffix_array_substring_search #(
   parameter int MAX_TEXT    = sass_pkg::MAX_TEXT_DEF,
   parameter int MAX_PATTERN = sass_pkg::MAX_PATTERN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sass_pkg::REQ_DATA_W-1:0]  req_tdata,  // cmd[2:0], char_byte[10:3]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sass_pkg::RSP_DATA_W-1:0]  rsp_tdata   // found[0], overflow[1]
);

   localparam int IW = $clog2(MAX_TEXT);
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RW = (IW > 8) ? IW : 8;

   sass_pkg::dp_ctl_type ctl;
   logic [IW-1:0] text_raddr, ord_wdata, ord_q;
   logic [PW-1:0] pat_raddr;
   logic [IW:0]   ord_raddr, ord_waddr, rank_raddr, rank_waddr;
   logic [RW-1:0] rank_wdata, rank_q;
   logic [7:0]    text_q, pat_q;
   logic [IW:0]   text_len, idx_len;
   logic [PW:0]   pat_len;
   logic          ovf, rsp_found, rsp_overflow;

   sass_control #(.MAX_TEXT(MAX_TEXT), .MAX_PATTERN(MAX_PATTERN)) u_control (
      .clock, .reset,
      .req_tvalid, .req_tready,
      .req_cmd(req_tdata[2:0]),
      .rsp_tvalid, .rsp_tready, .rsp_found, .rsp_overflow,
      .ctl, .text_raddr, .pat_raddr, .ord_raddr, .ord_waddr, .ord_wdata,
      .rank_raddr, .rank_waddr, .rank_wdata,
      .text_q, .pat_q, .ord_q, .rank_q, .text_len, .pat_len, .idx_len, .ovf
   );

   sass_datapath #(.MAX_TEXT(MAX_TEXT), .MAX_PATTERN(MAX_PATTERN)) u_datapath (
      .clock, .reset, .ctl,
      .char_byte(req_tdata[10:3]),
      .text_raddr, .pat_raddr, .ord_raddr, .ord_waddr, .ord_wdata,
      .rank_raddr, .rank_waddr, .rank_wdata,
      .text_q, .pat_q, .ord_q, .rank_q, .text_len, .pat_len, .idx_len, .ovf
   );

   assign rsp_tdata = {{(sass_pkg::RSP_DATA_W-2){1'b0}}, rsp_overflow, rsp_found};

endmodule
